/* hw/rtl/nked_pkg.sv */
// Package for the nearest keyword edit distance unit.
// Holds the dictionary ROM, word lengths, widths and the saturating increment.
// No dependencies.
package nked_pkg;

  localparam int NUM_WORDS    = 9;
  localparam int MAX_WORD_LEN = 7;
  localparam int DEPTH        = MAX_WORD_LEN + 1;
  localparam int COL_W        = $clog2(DEPTH);
  localparam int ROM_IDX_W    = $clog2(MAX_WORD_LEN);
  localparam int WORD_IDX_W   = $clog2(NUM_WORDS);
  localparam int DIST_W       = 16;

  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROM_IDX_W-1:0]  rom_idx_t;
  typedef logic [WORD_IDX_W-1:0] word_idx_t;
  typedef logic [DIST_W-1:0]     dist_t;

  // One DP column across all words
  typedef logic [NUM_WORDS-1:0][DIST_W-1:0] row_t;

  typedef logic [7:0] name_rom_t [NUM_WORDS][MAX_WORD_LEN];

  localparam name_rom_t SLOT_NAME_ROM = '{
    '{"a", "c", "c", "e", "n", "t", 8'h00},
    '{"a", "l", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "u", "c", "c", "e", "s", "s"},
    '{"w", "a", "r", "n", 8'h00, 8'h00, 8'h00},
    '{"e", "r", "r", "o", "r", 8'h00, 8'h00},
    '{"t", "e", "x", "t", 8'h00, 8'h00, 8'h00},
    '{"m", "u", "t", "e", "d", 8'h00, 8'h00},
    '{"b", "o", "r", "d", "e", "r", 8'h00},
    '{"s", "u", "r", "f", "a", "c", "e"}
  };

  // Length of each slot name, up to its first zero byte
  localparam col_t WORD_LEN [NUM_WORDS] = '{
    3'd6, 3'd3, 3'd7, 3'd4, 3'd5, 3'd4, 3'd5, 3'd6, 3'd7
  };

  // Reset value of the suggestion floor
  localparam logic [3:0] MIN_DIST_RESET = 4'd2;

  // Reciprocal of three for a 16-bit dividend: floor(x / 3) = (x * RECIP3) >> 17
  localparam logic [DIST_W-1:0] RECIP3       = 16'd43691;
  localparam int                RECIP3_SHIFT = 17;

  function automatic dist_t inc_sat(dist_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

/* hw/rtl/nearest_keyword_edit_distance_unit.sv */
// Top level of the nearest keyword edit distance unit.
// Depends on nked_pkg for the dictionary ROM, widths and helpers.
//
// Usage: send the characters of a query name, one input word each, with
// last_i on the final word. An empty name is one word with has_char_i = 0
// and last_i = 1; a word with neither flag set is dropped. On the last word
// the unit returns one output word: the nearest dictionary slot (first slot
// wins a tie), its Levenshtein distance, an exact-match flag, whether the
// distance is within max(floor register, length / 3), and the name length.
// Both channels are valid/stall; a word moves on an edge with valid high and
// stall low. The floor register is written through cfg_we_i / cfg_wdata_i.
// A character word stalls the input while the unit computes the DP columns
// for it, one DP column per cycle through the column memory. A last word
// then stalls the input through the nearest-word scan and ST_FIN, which
// loads the output register once it is free. The output register holds a
// result while out_stall_i is high; a following name streams in meanwhile
// and waits only if its own result is ready before the old one leaves.
// Reset empties the output, sets the floor to 2 and marks every column of
// the DP memory as holding its column index; no clearing pass is needed.
module nearest_keyword_edit_distance_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        has_char_i,
  input  logic        last_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  slot_index_o,
  output logic [15:0] best_distance_o,
  output logic        exact_match_o,
  output logic        suggestion_found_o,
  output logic [15:0] name_length_o
);

  import nked_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COL,
    ST_SEARCH,
    ST_FIN
  } state_e;

  state_e    state_q;
  col_t      k_q;
  logic [7:0] char_q;
  logic      last_q;
  dist_t     first_q;
  dist_t     len_q;
  row_t      diag_q;
  row_t      ins_q;
  row_t      final_q;
  word_idx_t w_q;
  dist_t     best_q;
  word_idx_t best_w_q;
  logic [3:0] min_dist_q;
  logic [DIST_W-2:0] third_q;

  // Column memory and its read port
  row_t      mem_q [DEPTH];
  row_t      rd_q;
  logic      rdv_q;
  logic [DEPTH-1:0] col_valid_q;

  logic      in_acc;
  logic      out_free;
  logic      mem_we;
  logic      rows_clear;
  col_t      rd_addr;
  rom_idx_t  rom_idx;
  row_t      old_row;
  row_t      new_row;
  dist_t     sub_v [NUM_WORDS];
  dist_t     del_v [NUM_WORDS];
  dist_t     ins_v [NUM_WORDS];
  dist_t     limit;
  logic [2*DIST_W-1:0] prod;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;
  assign mem_we     = (state_q == ST_COL);
  assign rows_clear = (state_q == ST_FIN) && out_free;
  assign rd_addr    = (state_q == ST_COL) ? col_t'(k_q + 1'b1) : '0;
  assign rom_idx    = (k_q == '0) ? '0 : rom_idx_t'(k_q - 1'b1);

  // Compute one DP column for all words from the column just read
  always_comb begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      old_row[w] = rdv_q ? rd_q[w] : dist_t'(k_q);
      sub_v[w]   = (SLOT_NAME_ROM[w][rom_idx] == char_q) ? diag_q[w] : inc_sat(diag_q[w]);
      del_v[w]   = inc_sat(old_row[w]);
      ins_v[w]   = inc_sat(ins_q[w]);
      if (k_q == '0) begin
        new_row[w] = first_q;
      end else begin
        new_row[w] = (del_v[w] < ins_v[w]) ? del_v[w] : ins_v[w];
        if (sub_v[w] < new_row[w]) begin
          new_row[w] = sub_v[w];
        end
      end
    end
  end

  // Suggestion threshold: max(floor, length / 3)
  assign prod  = len_q * RECIP3;
  assign limit = (dist_t'(third_q) < dist_t'(min_dist_q)) ? dist_t'(min_dist_q)
                                                         : dist_t'(third_q);

  // Hold the length divided by three
  always_ff @(posedge clk_i) begin
    third_q <= prod[RECIP3_SHIFT +: DIST_W-1];
  end

  // Write the column back and read the next one
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[k_q] <= new_row;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Track which columns hold written data; others read as column index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_valid_q <= '0;
      rdv_q       <= 1'b0;
    end else begin
      if (rows_clear) begin
        col_valid_q <= '0;
      end else if (mem_we) begin
        col_valid_q[k_q] <= 1'b1;
      end
      rdv_q <= col_valid_q[rd_addr];
    end
  end

  // Latch the suggestion floor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= MIN_DIST_RESET;
    end else if (cfg_we_i) begin
      min_dist_q <= cfg_wdata_i;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      k_q                <= '0;
      char_q             <= '0;
      last_q             <= 1'b0;
      first_q            <= '0;
      len_q              <= '0;
      diag_q             <= '0;
      ins_q              <= '0;
      w_q                <= '0;
      best_q             <= '0;
      best_w_q           <= '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        final_q[w] <= dist_t'(WORD_LEN[w]);
      end
      out_valid_o        <= 1'b0;
      slot_index_o       <= '0;
      best_distance_o    <= '0;
      exact_match_o      <= 1'b0;
      suggestion_found_o <= 1'b0;
      name_length_o      <= '0;
    end else begin
      // drop the result once taken
      if (out_valid_o && !out_stall_i && !rows_clear) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            char_q  <= char_code_i;
            last_q  <= last_i;
            first_q <= inc_sat(len_q);
            if (has_char_i) begin
              k_q     <= '0;
              state_q <= ST_COL;
            end else if (last_i) begin
              w_q     <= '0;
              state_q <= ST_SEARCH;
            end
          end
        end
        ST_COL: begin
          diag_q <= old_row;
          ins_q  <= new_row;
          for (int w = 0; w < NUM_WORDS; w++) begin
            if (WORD_LEN[w] == k_q) begin
              final_q[w] <= new_row[w];
            end
          end
          if (k_q == col_t'(MAX_WORD_LEN)) begin
            len_q <= first_q;
            if (last_q) begin
              w_q     <= '0;
              state_q <= ST_SEARCH;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            k_q <= col_t'(k_q + 1'b1);
          end
        end
        ST_SEARCH: begin
          // scan one word per cycle, first word wins a tie
          if (w_q == '0 || final_q[w_q] < best_q) begin
            best_q   <= final_q[w_q];
            best_w_q <= w_q;
          end
          if (w_q == word_idx_t'(NUM_WORDS - 1)) begin
            state_q <= ST_FIN;
          end else begin
            w_q <= word_idx_t'(w_q + 1'b1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_o        <= 1'b1;
            slot_index_o       <= 4'(best_w_q);
            best_distance_o    <= best_q;
            exact_match_o      <= (best_q == '0);
            suggestion_found_o <= (best_q <= limit);
            name_length_o      <= len_q;
            len_q              <= '0;
            for (int w = 0; w < NUM_WORDS; w++) begin
              final_q[w] <= dist_t'(WORD_LEN[w]);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A new result appears only out of the final step
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result appeared outside the final step");

  // Column write and next-column read never hit the same entry
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COL && k_q != col_t'(MAX_WORD_LEN)) |-> (rd_addr != k_q))
    else $error("column read and write collide");

  // Edit distance is bounded by the longer of the two strings
  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (best_distance_o <= name_length_o) ||
                    (best_distance_o <= 16'(MAX_WORD_LEN)))
    else $error("distance exceeds both string lengths");

  // An exact match needs a name no longer than a dictionary word
  a_exact_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && exact_match_o) |-> (name_length_o <= 16'(MAX_WORD_LEN)))
    else $error("exact match on an overlong name");

endmodule

/* verif/tb_top.sv */
// Testbench for nearest_keyword_edit_distance_unit: streams query names, predicts the
// nearest dictionary slot with its own Levenshtein rows, and checks every output word.
// Depends on the unit's RTL only; random stall and gap patterns come from $urandom.
module tb_top;

  localparam int N_SLOTS        = 9;
  localparam int MAX_LEN        = 7;
  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_WAIT       = 17;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 100;
  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct {
    logic [7:0] code;
    logic       has_char;
    logic       last;
  } name_word_t;

  typedef struct {
    logic [3:0]  slot;
    logic [15:0] edit_dist;
    logic        exact;
    logic        suggest;
    logic [15:0] length;
  } match_t;

  // DUT connections
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [3:0]  cfg_wdata   = 4'd0;
  logic        in_valid    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code   = 8'd0;
  logic        has_char    = 1'b0;
  logic        last        = 1'b0;
  logic        out_valid_o;
  logic        out_stall   = 1'b0;
  logic [3:0]  slot_index_o;
  logic [15:0] best_distance_o;
  logic        exact_match_o;
  logic        suggestion_found_o;
  logic [15:0] name_length_o;

  // Predictor state
  string       slot_words [N_SLOTS] = '{"accent", "alt", "success", "warn", "error",
                                        "text", "muted", "border", "surface"};
  logic [15:0] dist_rows [N_SLOTS][MAX_LEN+1];
  logic [15:0] chars_seen;
  logic [3:0]  suggest_floor = 4'd2;

  name_word_t  query_words [$];
  match_t      due_matches [$];
  name_word_t  cur_word;
  int          mismatches    = 0;
  int          gap_left      = 0;
  int          hold_left     = 0;
  int unsigned hold_draw;
  int          results_taken = 0;
  int          idle_cycles   = 0;
  bit          tx_quiet      = 1'b0;
  bit          rx_quiet      = 1'b0;

  nearest_keyword_edit_distance_unit i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .char_code_i        (char_code),
    .has_char_i         (has_char),
    .last_i             (last),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .slot_index_o       (slot_index_o),
    .best_distance_o    (best_distance_o),
    .exact_match_o      (exact_match_o),
    .suggestion_found_o (suggestion_found_o),
    .name_length_o      (name_length_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic logic [15:0] bump16(logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  // Return every row to its column index and forget the name
  task automatic clear_rows();
    for (int w = 0; w < N_SLOTS; w++) begin
      for (int j = 0; j <= MAX_LEN; j++) begin
        dist_rows[w][j] = j[15:0];
      end
    end
    chars_seen = 16'd0;
  endtask

  // Advance every slot row by one query character
  task automatic extend_rows(input logic [7:0] c);
    logic [15:0] nxt [MAX_LEN+1];
    logic [15:0] diag, sub, del, ins, best;
    string       wd;
    for (int w = 0; w < N_SLOTS; w++) begin
      wd = slot_words[w];
      nxt[0] = bump16(chars_seen);
      for (int j = 0; j < wd.len(); j++) begin
        diag = dist_rows[w][j];
        sub  = (wd[j] == c) ? diag : bump16(diag);
        del  = bump16(dist_rows[w][j+1]);
        ins  = bump16(nxt[j]);
        best = (del < ins) ? del : ins;
        nxt[j+1] = (sub < best) ? sub : best;
      end
      for (int j = 0; j <= wd.len(); j++) begin
        dist_rows[w][j] = nxt[j];
      end
    end
    chars_seen = bump16(chars_seen);
  endtask

  // Predict the outcome of one accepted input word
  task automatic predict_word(input name_word_t nw);
    match_t      m;
    logic [15:0] d, limit;
    if (nw.has_char) begin
      extend_rows(nw.code);
    end
    if (nw.last) begin
      m.slot      = 4'd0;
      m.edit_dist = dist_rows[0][slot_words[0].len()];
      for (int w = 1; w < N_SLOTS; w++) begin
        d = dist_rows[w][slot_words[w].len()];
        if (d < m.edit_dist) begin
          m.edit_dist = d;
          m.slot      = w[3:0];
        end
      end
      limit = chars_seen / 16'd3;
      if (limit < {12'd0, suggest_floor}) begin
        limit = {12'd0, suggest_floor};
      end
      m.exact   = (m.edit_dist == 16'd0);
      m.suggest = (m.edit_dist <= limit);
      m.length  = chars_seen;
      due_matches = {due_matches, m};
      clear_rows();
    end
  endtask

  // Compare one output word against the oldest prediction
  task automatic check_match();
    match_t want;
    if (due_matches.size() == 0) begin
      flag_mismatch("output word with nothing due", slot_index_o, -1);
    end else begin
      want = due_matches.pop_front();
      if (slot_index_o !== want.slot)
        flag_mismatch("slot_index", slot_index_o, want.slot);
      if (best_distance_o !== want.edit_dist)
        flag_mismatch("best_distance", best_distance_o, want.edit_dist);
      if (exact_match_o !== want.exact)
        flag_mismatch("exact_match", exact_match_o, want.exact);
      if (suggestion_found_o !== want.suggest)
        flag_mismatch("suggestion_found", suggestion_found_o, want.suggest);
      if (name_length_o !== want.length)
        flag_mismatch("name_length", name_length_o, want.length);
    end
  endtask

  task automatic push_word(input logic [7:0] c, input logic h, input logic l);
    name_word_t nw;
    nw.code     = c;
    nw.has_char = h;
    nw.last     = l;
    query_words = {query_words, nw};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_word(s[i], 1'b1, i == s.len() - 1);
    end
  endtask

  // Queue one random name; mostly near-miss slot names, some noise and long names
  task automatic queue_random_name(output int counted);
    logic [7:0] txt [$];
    logic [7:0] ch;
    string      base;
    int         mode, n, pos;
    bit         split_end;
    counted = 0;
    mode = $urandom_range(0, 9);
    if (mode <= 6) begin
      base = slot_words[$urandom_range(0, N_SLOTS - 1)];
      for (int i = 0; i < base.len(); i++) txt = {txt, base[i]};
      repeat ($urandom_range(0, 3)) begin
        pos = $urandom_range(0, txt.size());
        ch  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(97, 122));
        case ($urandom_range(0, 2))
          0: txt.insert(pos, ch);
          1: if (pos < txt.size()) txt.delete(pos);
          default: if (pos < txt.size()) txt[pos] = ch;
        endcase
      end
    end else if (mode == 8) begin
      n = $urandom_range(13, 40);
      repeat (n) txt = {txt, 8'($urandom_range(97, 122))};
    end else begin
      n = (mode == 7) ? $urandom_range(0, 12) : $urandom_range(0, 3);
      repeat (n) txt = {txt, 8'($urandom)};
    end
    split_end = (txt.size() == 0) || ($urandom_range(0, 4) == 0);
    foreach (txt[i]) begin
      if ($urandom_range(0, 11) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      push_word(txt[i], 1'b1, !split_end && (i == txt.size() - 1));
      counted++;
    end
    if (split_end) begin
      push_word(8'($urandom), 1'b0, 1'b1);
      counted++;
    end
  endtask

  // Wait until every queued word is in and every prediction is met
  task automatic drain();
    while (query_words.size() != 0 || in_valid || due_matches.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_floor(input logic [3:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we        <= 1'b0;
    suggest_floor = v;
    @(negedge clk_i);
  endtask

  // Driver: offer queued words, holding each until it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predict_word(cur_word);
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (query_words.size() != 0) begin
          cur_word  = query_words.pop_front();
          in_valid  <= 1'b1;
          char_code <= cur_word.code;
          has_char  <= cur_word.has_char;
          last      <= cur_word.last;
          gap_left  <= tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
          if ($urandom_range(0, 19) == 0) tx_quiet <= !tx_quiet;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take output words, then stall for a drawn count of cycles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid_o && !out_stall) begin
      check_match();
      results_taken <= results_taken + 1;
      if (results_taken == 30 || results_taken == 70) hold_draw = LONG_HOLD;
      else if (rx_quiet) hold_draw = 0;
      else hold_draw = $urandom_range(0, MAX_WAIT);
      if ($urandom_range(0, 19) == 0) rx_quiet <= !rx_quiet;
      hold_left <= hold_draw;
      out_stall <= (hold_draw != 0);
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          counted, got;
    logic [3:0]  floors [5];
    clear_rows();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed names at the reset floor
    push_word(8'h00, 1'b0, 1'b1);          // empty name
    push_word(8'hA5, 1'b0, 1'b0);          // dropped word
    push_text("alt");                      // exact match
    push_word("t", 1'b1, 1'b0);            // name closed by a word without a character
    push_word("e", 1'b1, 1'b0);
    push_word("x", 1'b1, 1'b0);
    push_word("t", 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 1'b1);
    push_word(8'h00, 1'b1, 1'b0);          // extreme character codes
    push_word(8'hFF, 1'b1, 1'b1);
    push_text("surface");
    push_text("eror");
    drain();

    // Random names over several floor settings, extremes included
    floors[0] = 4'd0;
    floors[1] = 4'd15;
    floors[2] = 4'($urandom_range(1, 14));
    floors[3] = 4'($urandom_range(0, 15));
    floors[4] = 4'd2;
    foreach (floors[p]) begin
      set_floor(floors[p]);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        queue_random_name(got);
        counted += got;
      end
      drain();
    end

    if (due_matches.size() != 0) begin
      flag_mismatch("output words never seen", due_matches.size(), 0);
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
